// ===== src/lqnt_pkg.sv =====
// ----------------------------------------------------------------------------
// lqnt_pkg
// Shared constants and slot record for the link-quality neighbor table.
// ----------------------------------------------------------------------------
`default_nettype none

package lqnt_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;

    localparam int ID_W     = 8;
    localparam int RSSI_W   = 8;
    localparam int RATIO_W  = 23;
    localparam int CREDIT_W = 7;
    localparam int CNT_W    = 16;
    localparam int STEP_W   = 6;
    localparam int REG_IDX_W = 2;
    localparam int REG_DATA_W = 7;

    localparam logic [CNT_W-1:0]    CNT_MAX     = 16'hFFFF;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 7'd127;
    localparam logic [6:0]          PERCENT     = 7'd100;

    localparam logic [CREDIT_W-1:0] INIT_CREDIT_RST = 7'd20;
    localparam logic [STEP_W-1:0]   CREDIT_STEP_RST = 6'd10;
    localparam logic [STEP_W-1:0]   CREDIT_LIM_RST  = 6'd30;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INIT_CREDIT = 2'd0,
        REG_CREDIT_STEP = 2'd1,
        REG_CREDIT_LIM  = 2'd2
    } reg_idx_t;

    localparam logic ACT_RECEIVE  = 1'b0;
    localparam logic ACT_TRANSMIT = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [RSSI_W-1:0] rssi;
        logic [RATIO_W-1:0]       ratio;
        logic [CREDIT_W-1:0]      credit;
        logic [CNT_W-1:0]         received;
        logic [CNT_W-1:0]         sent;
    } slot_t;

endpackage

`default_nettype wire

// ===== src/link_quality_neighbor_table_top.sv =====
// ----------------------------------------------------------------------------
// link_quality_neighbor_table_top
// Neighbor table with per-neighbor delivery ratio, credit aging and an
// rssi-ordered dump after every received packet.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | action, sender_id, rssi
//  m_      | out       | m_valid / m_ready  | node_id .. sent_count, last
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// A transmit item counts a sent packet and s_ready stays high. A receive item
// walks the table one slot a cycle for lookup, updates or inserts the sender's
// entry, runs a 24-bit restoring divider one quotient bit a cycle, ages the
// table one slot a cycle, runs the exchange sort one compare a cycle, finds the
// last occupied slot and emits the occupied slots, stepping one slot a cycle
// unless m_ready stalls it. The divider is skipped for a new sender, for sender
// id 0 or while no packet was sent. Reset clears the table and counters at once.
// s_ready is low while an item is in work; a stalled m_ready holds the dump.
`default_nettype none

module link_quality_neighbor_table_top
    import lqnt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_we,
    input  wire [REG_IDX_W-1:0]        cfg_index,
    input  wire [REG_DATA_W-1:0]       cfg_data,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_action,
    input  wire [ID_W-1:0]             s_sender_id,
    input  wire signed [RSSI_W-1:0]    s_rssi,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [ID_W-1:0]            m_node_id,
    output logic signed [RSSI_W-1:0]   m_entry_rssi,
    output logic [RATIO_W-1:0]         m_delivery_ratio,
    output logic [CREDIT_W-1:0]        m_credit,
    output logic [CNT_W-1:0]           m_received_count,
    output logic [CNT_W-1:0]           m_sent_count,
    output logic                       m_last
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_IW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_IW-1:0] LAST_IDX = CNT_IW'(TABLE_ENTRIES - 1);
    localparam int NUM_W = 24;
    localparam int DIV_STEPS = NUM_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOK, ST_HEAR, ST_DIV, ST_DIVDONE, ST_AGE,
        ST_SORT, ST_FINDLAST, ST_EMIT
    } state_t;

    state_t state_reg;
    slot_t  slots_reg [TABLE_ENTRIES];
    logic [CNT_W-1:0]    tx_cnt_reg;
    logic [CREDIT_W-1:0] init_credit_reg;
    logic [STEP_W-1:0]   credit_step_reg, credit_lim_reg;

    logic [ID_W-1:0]          sender_reg;
    logic signed [RSSI_W-1:0] rssi_reg;
    logic [CNT_IW-1:0]        i_reg, j_reg;
    logic [IDX_W-1:0]         hit_reg, empty_reg;
    logic                     hit_ok_reg, empty_ok_reg;
    logic [NUM_W-1:0]         quo_reg, rem_reg;
    logic [CNT_W-1:0]         den_reg;
    logic [$clog2(DIV_STEPS+1)-1:0] step_reg;
    logic [IDX_W-1:0]         lastpos_reg;

    // restoring divider step
    logic [NUM_W:0]   div_trial;
    logic [NUM_W-1:0] div_rem_sh;
    assign div_rem_sh = {rem_reg[NUM_W-2:0], quo_reg[NUM_W-1]};
    assign div_trial  = {1'b0, div_rem_sh} - {{(NUM_W-CNT_W+1){1'b0}}, den_reg};

    logic [IDX_W-1:0] ii, jj;
    assign ii = i_reg[IDX_W-1:0];
    assign jj = j_reg[IDX_W-1:0];

    slot_t cur_s;
    assign cur_s = slots_reg[ii];

    logic [CNT_W-1:0] rcv_inc;
    assign rcv_inc = (slots_reg[hit_reg].received != CNT_MAX)
                   ? slots_reg[hit_reg].received + 1'b1 : CNT_MAX;

    logic [CREDIT_W:0] credit_sum;
    assign credit_sum = {1'b0, slots_reg[hit_reg].credit}
                      + {{(CREDIT_W-STEP_W+1){1'b0}}, credit_step_reg};

    // output view of the current slot
    assign m_node_id        = cur_s.id;
    assign m_entry_rssi     = cur_s.rssi;
    assign m_delivery_ratio = cur_s.ratio;
    assign m_credit         = cur_s.credit;
    assign m_received_count = cur_s.received;
    assign m_sent_count     = cur_s.sent;
    assign m_last           = (ii == lastpos_reg);
    assign m_valid          = (state_reg == ST_EMIT) && (cur_s.id != '0);
    assign s_ready          = (state_reg == ST_IDLE);

    // sequencer, table and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            tx_cnt_reg      <= '0;
            init_credit_reg <= INIT_CREDIT_RST;
            credit_step_reg <= CREDIT_STEP_RST;
            credit_lim_reg  <= CREDIT_LIM_RST;
            i_reg           <= '0;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                slots_reg[k] <= '0;
            end
        end else begin
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_INIT_CREDIT: init_credit_reg <= cfg_data;
                    REG_CREDIT_STEP: credit_step_reg <= cfg_data[STEP_W-1:0];
                    REG_CREDIT_LIM:  credit_lim_reg  <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_action == ACT_TRANSMIT) begin
                            if (tx_cnt_reg != CNT_MAX) tx_cnt_reg <= tx_cnt_reg + 1'b1;
                        end else begin
                            sender_reg   <= s_sender_id;
                            rssi_reg     <= s_rssi;
                            i_reg        <= '0;
                            hit_ok_reg   <= 1'b0;
                            empty_ok_reg <= 1'b0;
                            state_reg    <= ST_LOOK;
                        end
                    end
                end
                // refresh sent count, find sender and first empty slot
                ST_LOOK: begin
                    slots_reg[ii].sent <= tx_cnt_reg;
                    if (!hit_ok_reg && cur_s.id == sender_reg) begin
                        hit_ok_reg <= 1'b1;
                        hit_reg    <= ii;
                    end
                    if (!empty_ok_reg && cur_s.id == '0) begin
                        empty_ok_reg <= 1'b1;
                        empty_reg    <= ii;
                    end
                    if (i_reg == LAST_IDX) begin
                        state_reg <= ST_HEAR;
                    end
                    i_reg <= i_reg + 1'b1;
                end
                ST_HEAR: begin
                    i_reg     <= '0;
                    state_reg <= ST_AGE;
                    if (sender_reg != '0) begin
                        if (hit_ok_reg) begin
                            slots_reg[hit_reg].received <= rcv_inc;
                            slots_reg[hit_reg].rssi     <= rssi_reg;
                            if (slots_reg[hit_reg].credit
                                < {1'b0, credit_lim_reg}) begin
                                slots_reg[hit_reg].credit <=
                                    credit_sum[CREDIT_W] ? CREDIT_MAX
                                                         : credit_sum[CREDIT_W-1:0];
                            end
                            if (tx_cnt_reg != '0) begin
                                quo_reg   <= NUM_W'(rcv_inc) * NUM_W'(PERCENT);
                                rem_reg   <= '0;
                                den_reg   <= tx_cnt_reg;
                                step_reg  <= '0;
                                state_reg <= ST_DIV;
                            end
                        end else if (empty_ok_reg) begin
                            slots_reg[empty_reg] <= '{id: sender_reg, rssi: rssi_reg,
                                ratio: '0, credit: init_credit_reg, received: 16'd1,
                                sent: tx_cnt_reg};
                        end
                    end
                end
                // one quotient bit a cycle
                ST_DIV: begin
                    if (!div_trial[NUM_W]) begin
                        rem_reg <= div_trial[NUM_W-1:0];
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= div_rem_sh;
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == DIV_STEPS - 1) state_reg <= ST_DIVDONE;
                end
                ST_DIVDONE: begin
                    slots_reg[hit_reg].ratio <= quo_reg[RATIO_W-1:0];
                    state_reg <= ST_AGE;
                end
                // age one slot a cycle
                ST_AGE: begin
                    if (cur_s.id != '0) begin
                        if (cur_s.credit <= 7'd1) slots_reg[ii] <= '0;
                        else slots_reg[ii].credit <= cur_s.credit - 1'b1;
                    end
                    if (i_reg == LAST_IDX) begin
                        i_reg     <= '0;
                        j_reg     <= CNT_IW'(1);
                        state_reg <= ST_SORT;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                // exchange sort, one compare a cycle
                ST_SORT: begin
                    if (cur_s.rssi < slots_reg[jj].rssi) begin
                        slots_reg[ii] <= slots_reg[jj];
                        slots_reg[jj] <= cur_s;
                    end
                    if (j_reg == LAST_IDX) begin
                        if (i_reg == LAST_IDX - 1'b1) begin
                            i_reg     <= '0;
                            state_reg <= ST_FINDLAST;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg + 2'd2;
                        end
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                // locate the last occupied slot
                ST_FINDLAST: begin
                    if (cur_s.id != '0) lastpos_reg <= ii;
                    if (i_reg == LAST_IDX) begin
                        i_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                // transfer occupied slots, skip empty ones
                ST_EMIT: begin
                    if (cur_s.id == '0 || m_ready) begin
                        if (i_reg == LAST_IDX) begin
                            i_reg     <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
